FILE: hdl/gpc_pkg.sv
// Shared types, codes and the axis permutation table of the point set checker.
// No dependencies; used by the controller, the datapath and the checker.
package gpc_pkg;

  typedef logic [3:0]       coord_t;
  typedef coord_t [2:0]     point_t;   // [0] x, [1] y, [2] z

  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] VERD_FITS      = 2'd0;
  localparam logic [1:0] VERD_LAYER     = 2'd1;
  localparam logic [1:0] VERD_COLLINEAR = 2'd2;
  localparam logic [1:0] VERD_COPLANAR  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_OUTSIDE = 2'd3;

  localparam logic [1:0] LAYER_LIMIT = 2'd3;
  localparam logic [4:0] SIDE_RESET  = 5'd4;
  localparam logic [4:0] SIDE_MIN    = 5'd2;
  localparam logic [2:0] DRAIN_CYC   = 3'd5;
  localparam logic [2:0] LAST_PERM   = 3'd5;
  localparam logic [2:0] LAST_REFL   = 3'd7;

  // source axis for each destination axis, two bits per axis
  localparam logic [5:0] PERM_TAB [6] = '{
    6'b10_01_00, 6'b01_10_00, 6'b10_00_01,
    6'b00_10_01, 6'b01_00_10, 6'b00_01_10
  };

  typedef enum logic [2:0] {
    OP_NONE, OP_LD_A, OP_LD_B, OP_DUP, OP_LINE, OP_PLANE, OP_SYM
  } dp_op_e;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    dp_op_e     op;
    logic       push;
    logic       pop;
    logic       clr_sticky;
    logic [2:0] perm;
    logic [2:0] refl;
  } dp_cmd_t;

  typedef struct packed {
    logic oob;
    logic lfull;
    logic full;
    logic empty;
    logic sticky;
  } dp_stat_t;

  function automatic logic [1:0] perm_axis(input logic [2:0] p, input logic [1:0] a);
    logic [5:0] row;
    row = (p > LAST_PERM) ? PERM_TAB[0] : PERM_TAB[p];
    return row[2*a +: 2];
  endfunction

endpackage

FILE: hdl/gpc_in_if.sv
// Input channel of the point set checker: command and candidate point.
// Depends on nothing.
interface gpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] px;
  logic [3:0] py;
  logic [3:0] pz;
  modport source (output valid, command, px, py, pz, input ready);
  modport sink   (input valid, command, px, py, pz, output ready);
endinterface

FILE: hdl/gpc_out_if.sv
// Output channel of the point set checker: one result word per command.
// Depends on nothing.
interface gpc_out_if;
  logic       valid;
  logic       ready;
  logic       fits_flag;
  logic [1:0] verdict;
  logic       symmetric;
  logic [5:0] point_total;
  logic [1:0] status;
  modport source (output valid, fits_flag, verdict, symmetric, point_total, status,
                  input ready);
  modport sink   (input valid, fits_flag, verdict, symmetric, point_total, status,
                  output ready);
endinterface

FILE: hdl/gpc_datapath.sv
// Datapath: point memory, layer counts, grid side and the 3-stage
// collinear/coplanar/match pipeline. Depends on gpc_pkg.
module gpc_datapath #(
  parameter int MAX_POINTS = 40,
  parameter int MAX_SIDE   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [4:0]                      cfg_wdata_i,
  input  logic [3:0]                      px_i,
  input  logic [3:0]                      py_i,
  input  logic [3:0]                      pz_i,
  input  gpc_pkg::dp_cmd_t                cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]   addr_i,
  output gpc_pkg::dp_stat_t               stat_o,
  output logic [$clog2(MAX_POINTS+1)-1:0] count_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam logic [3:0] LMASK = 4'(MAX_SIDE - 1);

  logic [4:0]        side_q;
  logic [4:0]        side_n;
  logic [3:0]        m;
  gpc_pkg::point_t   q_q, rdat_q, a_q, b_q;
  gpc_pkg::point_t   mem_q [MAX_POINTS];
  logic [CW-1:0]     count_q;
  logic [1:0]        lay_q [3][MAX_SIDE];
  logic [LW-1:0]     qi [3];
  logic [LW-1:0]     ri [3];
  gpc_pkg::dp_op_e   op0_q, op1_q;
  logic signed [4:0] cv [3];
  logic signed [4:0] sv [3];
  logic signed [4:0] uv [3];
  logic [4:0]        tv [3];
  logic signed [10:0] cr [3];
  logic signed [10:0] cr_q [3];
  logic signed [4:0] u_q [3];
  logic              eq1, eq_q;
  logic signed [17:0] dot, dot_q;
  logic              hit2_q, pl2_q, sticky_q;
  logic              oob, lfull, dup_m, sym_m;
  logic [1:0]        ax;

  always_comb begin
    if (side_q < gpc_pkg::SIDE_MIN) side_n = gpc_pkg::SIDE_MIN;
    else if (side_q > 5'(MAX_SIDE)) side_n = 5'(MAX_SIDE);
    else side_n = side_q;
    m = 4'(side_n - 5'd1);
  end

  always_comb begin
    oob   = 1'b0;
    lfull = 1'b0;
    dup_m = 1'b1;
    sym_m = 1'b1;
    ax    = 2'd0;
    for (int a = 0; a < 3; a++) begin
      qi[a] = LW'(q_q[a] & LMASK);
      ri[a] = LW'(rdat_q[a] & LMASK);
      if ({1'b0, q_q[a]} >= side_n) oob = 1'b1;
      if (lay_q[a][qi[a]] == gpc_pkg::LAYER_LIMIT) lfull = 1'b1;
      cv[a] = $signed({1'b0, rdat_q[a]}) - $signed({1'b0, q_q[a]});
      uv[a] = $signed({1'b0, a_q[a]}) - $signed({1'b0, q_q[a]});
      sv[a] = (op0_q == gpc_pkg::OP_LINE) ? uv[a]
            : $signed({1'b0, b_q[a]}) - $signed({1'b0, q_q[a]});
      ax    = gpc_pkg::perm_axis(cmd_i.perm, 2'(a));
      tv[a] = cmd_i.refl[a] ? {1'b0, m} - {1'b0, a_q[ax]} : {1'b0, a_q[ax]};
      if (rdat_q[a] != q_q[a]) dup_m = 1'b0;
      if ({1'b0, rdat_q[a]} != tv[a]) sym_m = 1'b0;
    end
    cr[0] = 11'(sv[1]) * 11'(cv[2]) - 11'(sv[2]) * 11'(cv[1]);
    cr[1] = 11'(sv[2]) * 11'(cv[0]) - 11'(sv[0]) * 11'(cv[2]);
    cr[2] = 11'(sv[0]) * 11'(cv[1]) - 11'(sv[1]) * 11'(cv[0]);
    eq1   = (op0_q == gpc_pkg::OP_DUP && dup_m) || (op0_q == gpc_pkg::OP_SYM && sym_m);
    dot   = 18'(u_q[0]) * 18'(cr_q[0]) + 18'(u_q[1]) * 18'(cr_q[1])
          + 18'(u_q[2]) * 18'(cr_q[2]);
  end

  // memory and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      q_q[0] <= px_i;
      q_q[1] <= py_i;
      q_q[2] <= pz_i;
    end
    if (cmd_i.push) mem_q[count_q[AW-1:0]] <= q_q;
    if (cmd_i.rd_en) rdat_q <= mem_q[addr_i];
    if (op0_q == gpc_pkg::OP_LD_A) a_q <= rdat_q;
    if (op0_q == gpc_pkg::OP_LD_B) b_q <= rdat_q;
    for (int a = 0; a < 3; a++) begin
      cr_q[a] <= cr[a];
      u_q[a]  <= uv[a];
    end
    eq_q  <= eq1;
    dot_q <= dot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= gpc_pkg::SIDE_RESET;
      count_q  <= '0;
      op0_q    <= gpc_pkg::OP_NONE;
      op1_q    <= gpc_pkg::OP_NONE;
      hit2_q   <= 1'b0;
      pl2_q    <= 1'b0;
      sticky_q <= 1'b0;
      for (int a = 0; a < 3; a++)
        for (int s = 0; s < MAX_SIDE; s++) lay_q[a][s] <= 2'd0;
    end else begin
      if (cfg_we_i) side_q <= cfg_wdata_i;
      op0_q  <= cmd_i.rd_en ? cmd_i.op : gpc_pkg::OP_NONE;
      op1_q  <= op0_q;
      hit2_q <= eq_q || (op1_q == gpc_pkg::OP_LINE &&
                cr_q[0] == '0 && cr_q[1] == '0 && cr_q[2] == '0);
      pl2_q  <= (op1_q == gpc_pkg::OP_PLANE);
      if (cmd_i.capture || cmd_i.clr_sticky) sticky_q <= 1'b0;
      else if (hit2_q || (pl2_q && dot_q == '0)) sticky_q <= 1'b1;
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
        for (int a = 0; a < 3; a++) lay_q[a][qi[a]] <= lay_q[a][qi[a]] + 2'd1;
      end else if (cmd_i.pop) begin
        count_q <= count_q - 1'b1;
        for (int a = 0; a < 3; a++)
          if (lay_q[a][ri[a]] != 2'd0) lay_q[a][ri[a]] <= lay_q[a][ri[a]] - 2'd1;
      end
    end
  end

  assign stat_o.oob    = oob;
  assign stat_o.lfull  = lfull;
  assign stat_o.full   = (count_q >= CW'(MAX_POINTS));
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.sticky = sticky_q;
  assign count_o       = count_q;

endmodule

FILE: hdl/gpc_ctrl.sv
// Controller: command sequencer walking stored points, pairs, triples and
// cube motions, plus the registered result word. Depends on gpc_pkg.
module gpc_ctrl #(
  parameter int MAX_POINTS = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            fits_o,
  output logic [1:0]                      verdict_o,
  output logic                            sym_o,
  output logic [5:0]                      total_o,
  output logic [1:0]                      status_o,
  output gpc_pkg::dp_cmd_t                cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]   addr_o,
  input  gpc_pkg::dp_stat_t               stat_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0] count_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DUP, S_LN_A, S_LN_C, S_PL_A, S_PL_B, S_PL_C,
    S_DRAIN, S_SY_A, S_SY_C, S_POP_W, S_POP_UPD, S_FIN, S_SETTLE, S_RESULT
  } state_e;

  typedef enum logic [1:0] {PH_LINE, PH_PLANE, PH_SYM} phase_e;

  state_e           state_q;
  phase_e           ph_q;
  logic [1:0]       cmdc_q;
  logic [CW-1:0]    ia_q, ib_q, ic_q;
  logic [2:0]       cnt_q, mp_q, ms_q;
  logic             fit_q, sym_q;
  logic [1:0]       verd_q, stat_q;
  gpc_pkg::dp_cmd_t cmd_q;
  logic [AW-1:0]    addr_q;
  logic             acc;
  logic             ia_last, ia_pl_end, ib_last, ic_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign addr_o     = addr_q;

  always_comb begin
    cmd_o         = cmd_q;
    cmd_o.capture = acc;
    cmd_o.perm    = mp_q;
    cmd_o.refl    = ms_q;
    ia_last   = ((CW+1)'(ia_q) + 1'b1) >= (CW+1)'(count_i);
    ia_pl_end = ((CW+1)'(ia_q) + 2'd2) >= (CW+1)'(count_i);
    ib_last   = ((CW+1)'(ib_q) + 1'b1) >= (CW+1)'(count_i);
    ic_last   = ((CW+1)'(ic_q) + 1'b1) >= (CW+1)'(count_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_LINE;
      cmdc_q      <= gpc_pkg::CMD_TEST;
      ia_q        <= '0;
      ib_q        <= '0;
      ic_q        <= '0;
      cnt_q       <= '0;
      mp_q        <= '0;
      ms_q        <= '0;
      fit_q       <= 1'b0;
      sym_q       <= 1'b0;
      verd_q      <= gpc_pkg::VERD_FITS;
      stat_q      <= gpc_pkg::STAT_OK;
      cmd_q       <= '0;
      addr_q      <= '0;
      out_valid_o <= 1'b0;
      fits_o      <= 1'b0;
      verdict_o   <= gpc_pkg::VERD_FITS;
      sym_o       <= 1'b0;
      total_o     <= '0;
      status_o    <= gpc_pkg::STAT_OK;
    end else begin
      cmd_q.rd_en      <= 1'b0;
      cmd_q.op         <= gpc_pkg::OP_NONE;
      cmd_q.push       <= 1'b0;
      cmd_q.pop        <= 1'b0;
      cmd_q.clr_sticky <= 1'b0;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (acc) begin
            cmdc_q  <= command_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          fit_q  <= 1'b0;
          sym_q  <= 1'b0;
          verd_q <= gpc_pkg::VERD_FITS;
          stat_q <= gpc_pkg::STAT_OK;
          ia_q   <= '0;
          case (cmdc_q)
            gpc_pkg::CMD_TEST, gpc_pkg::CMD_PUSH: begin
              if (stat_i.oob) begin
                stat_q  <= gpc_pkg::STAT_OUTSIDE;
                state_q <= S_RESULT;
              end else if (stat_i.lfull) begin
                verd_q  <= gpc_pkg::VERD_LAYER;
                state_q <= S_FIN;
              end else if (stat_i.empty) begin
                state_q <= S_FIN;
              end else begin
                state_q <= S_DUP;
              end
            end
            gpc_pkg::CMD_POP: begin
              if (stat_i.empty) begin
                stat_q  <= gpc_pkg::STAT_EMPTY;
                state_q <= S_RESULT;
              end else begin
                cmd_q.rd_en <= 1'b1;
                addr_q      <= AW'(count_i - 1'b1);
                state_q     <= S_POP_W;
              end
            end
            default: begin
              if (stat_i.empty) begin
                sym_q   <= 1'b1;
                state_q <= S_RESULT;
              end else begin
                mp_q    <= '0;
                ms_q    <= 3'd1;
                state_q <= S_SY_A;
              end
            end
          endcase
        end
        S_DUP: begin
          ph_q  <= PH_LINE;
          cnt_q <= '0;
          if (stat_i.sticky) begin
            state_q <= S_DRAIN;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_DUP;
            addr_q      <= ia_q[AW-1:0];
            if (ia_last) begin
              ia_q    <= '0;
              state_q <= S_LN_A;
            end else begin
              ia_q <= ia_q + 1'b1;
            end
          end
        end
        S_LN_A: begin
          cnt_q <= '0;
          if (stat_i.sticky || ia_last) begin
            state_q <= S_DRAIN;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_LD_A;
            addr_q      <= ia_q[AW-1:0];
            ib_q        <= ia_q + 1'b1;
            state_q     <= S_LN_C;
          end
        end
        S_LN_C: begin
          cnt_q <= '0;
          if (stat_i.sticky) begin
            state_q <= S_DRAIN;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_LINE;
            addr_q      <= ib_q[AW-1:0];
            if (ib_last) begin
              ia_q    <= ia_q + 1'b1;
              state_q <= S_LN_A;
            end else begin
              ib_q <= ib_q + 1'b1;
            end
          end
        end
        S_PL_A: begin
          cnt_q <= '0;
          if (stat_i.sticky || ia_pl_end) begin
            state_q <= S_DRAIN;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_LD_A;
            addr_q      <= ia_q[AW-1:0];
            ib_q        <= ia_q + 1'b1;
            state_q     <= S_PL_B;
          end
        end
        S_PL_B: begin
          cnt_q <= '0;
          if (stat_i.sticky) begin
            state_q <= S_DRAIN;
          end else if (ib_last) begin
            ia_q    <= ia_q + 1'b1;
            state_q <= S_PL_A;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_LD_B;
            addr_q      <= ib_q[AW-1:0];
            ic_q        <= ib_q + 1'b1;
            state_q     <= S_PL_C;
          end
        end
        S_PL_C: begin
          cnt_q <= '0;
          if (stat_i.sticky) begin
            state_q <= S_DRAIN;
          end else begin
            cmd_q.rd_en <= 1'b1;
            cmd_q.op    <= gpc_pkg::OP_PLANE;
            addr_q      <= ic_q[AW-1:0];
            if (ic_last) begin
              ib_q    <= ib_q + 1'b1;
              state_q <= S_PL_B;
            end else begin
              ic_q <= ic_q + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == gpc_pkg::DRAIN_CYC - 1'b1) begin
            cnt_q <= '0;
            case (ph_q)
              PH_LINE: begin
                if (stat_i.sticky) begin
                  verd_q  <= gpc_pkg::VERD_COLLINEAR;
                  state_q <= S_FIN;
                end else begin
                  ia_q    <= '0;
                  ph_q    <= PH_PLANE;
                  state_q <= S_PL_A;
                end
              end
              PH_PLANE: begin
                verd_q  <= stat_i.sticky ? gpc_pkg::VERD_COPLANAR : gpc_pkg::VERD_FITS;
                state_q <= S_FIN;
              end
              default: begin
                if (stat_i.sticky) begin
                  cmd_q.clr_sticky <= 1'b1;
                  if (ia_last) begin
                    sym_q   <= 1'b1;
                    state_q <= S_RESULT;
                  end else begin
                    ia_q    <= ia_q + 1'b1;
                    state_q <= S_SY_A;
                  end
                end else if (mp_q == gpc_pkg::LAST_PERM && ms_q == gpc_pkg::LAST_REFL) begin
                  state_q <= S_RESULT;
                end else begin
                  ia_q    <= '0;
                  state_q <= S_SY_A;
                  if (ms_q == gpc_pkg::LAST_REFL) begin
                    ms_q <= '0;
                    mp_q <= mp_q + 1'b1;
                  end else begin
                    ms_q <= ms_q + 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_SY_A: begin
          ph_q        <= PH_SYM;
          cmd_q.rd_en <= 1'b1;
          cmd_q.op    <= gpc_pkg::OP_LD_A;
          addr_q      <= ia_q[AW-1:0];
          ib_q        <= '0;
          state_q     <= S_SY_C;
        end
        S_SY_C: begin
          cnt_q       <= '0;
          cmd_q.rd_en <= 1'b1;
          cmd_q.op    <= gpc_pkg::OP_SYM;
          addr_q      <= ib_q[AW-1:0];
          if (ib_last) state_q <= S_DRAIN;
          else ib_q <= ib_q + 1'b1;
        end
        S_POP_W: state_q <= S_POP_UPD;
        S_POP_UPD: begin
          cmd_q.pop <= 1'b1;
          state_q   <= S_SETTLE;
        end
        S_FIN: begin
          fit_q   <= (verd_q == gpc_pkg::VERD_FITS);
          state_q <= S_RESULT;
          if (cmdc_q == gpc_pkg::CMD_PUSH) begin
            if (stat_i.full) begin
              stat_q <= gpc_pkg::STAT_FULL;
            end else if (verd_q == gpc_pkg::VERD_FITS) begin
              cmd_q.push <= 1'b1;
              state_q    <= S_SETTLE;
            end
          end
        end
        S_SETTLE: state_q <= S_RESULT;
        S_RESULT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            fits_o      <= fit_q;
            verdict_o   <= verd_q;
            sym_o       <= sym_q;
            total_o     <= 6'(count_i);
            status_o    <= stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/general_position_point_set_checker_top.sv
// Top level of the general position point set checker (no four coplanar, 3-D grid).
// Depends on gpc_pkg, gpc_in_if, gpc_out_if, gpc_ctrl and gpc_datapath.
//
// Usage: in_i carries one command word (test, test and push, pop, symmetry
// query) with a candidate point; out_o returns exactly one result word per
// command. grid_side is written through cfg_wdata_i/cfg_we_i, by the user
// only while idle; the block does not enforce this. One command is worked
// at a time; in_i.ready is high only when idle. Test and push walk the stored
// points, then pairs, then triples, and stop early on a reject; a query walks
// the stored points for each cube motion. The single read port of the point
// memory delivers one stored point a cycle, while the sequencer walks the
// set, into a 3-stage determinant pipeline.
// The result sits in an output register; a stalled receiver does not block
// acceptance of the next command, only the delivery of its result.
// Reset empties the stack, clears layer counts and sets grid_side to 4;
// the point memory itself is not cleared.
module general_position_point_set_checker_top #(
  parameter int MAX_POINTS = 40,
  parameter int MAX_SIDE   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [4:0]      cfg_wdata_i,
  gpc_in_if.sink          in_i,
  gpc_out_if.source       out_o
);

  gpc_pkg::dp_cmd_t                cmd;
  gpc_pkg::dp_stat_t               stat;
  logic [$clog2(MAX_POINTS)-1:0]   addr;
  logic [$clog2(MAX_POINTS+1)-1:0] count;

  gpc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .command_i   (in_i.command),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .fits_o      (out_o.fits_flag),
    .verdict_o   (out_o.verdict),
    .sym_o       (out_o.symmetric),
    .total_o     (out_o.point_total),
    .status_o    (out_o.status),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .stat_i      (stat),
    .count_i     (count)
  );

  gpc_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_SIDE(MAX_SIDE)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .px_i        (in_i.px),
    .py_i        (in_i.py),
    .pz_i        (in_i.pz),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .stat_o      (stat),
    .count_o     (count)
  );

endmodule

FILE: hdl/gpc_checker.sv
// Port-level checks of the point set checker, attached to the top by bind.
// Depends on gpc_pkg and general_position_point_set_checker_top.
module gpc_checker #(
  parameter int MAX_POINTS = 40
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       fits_i,
  input logic [1:0] verdict_i,
  input logic       sym_i,
  input logic [5:0] total_i,
  input logic [1:0] status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while busy");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 7'(total_i) <= 7'(MAX_POINTS))
    else $error("point total beyond capacity");

  a_fit_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fits_i |-> verdict_i == gpc_pkg::VERD_FITS &&
                              status_i != gpc_pkg::STAT_OUTSIDE)
    else $error("fit reported with a reject verdict");

  a_sym_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sym_i |-> !fits_i && verdict_i == gpc_pkg::VERD_FITS &&
                             status_i == gpc_pkg::STAT_OK)
    else $error("symmetry flag on a non-query word");

endmodule

bind general_position_point_set_checker_top gpc_checker #(.MAX_POINTS(MAX_POINTS)) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .fits_i      (out_o.fits_flag),
  .verdict_i   (out_o.verdict),
  .sym_i       (out_o.symmetric),
  .total_i     (out_o.point_total),
  .status_i    (out_o.status)
);

FILE: test/general_position_point_set_checker_top_tb.sv
// Self-checking testbench for general_position_point_set_checker_top.
// Needs gpc_pkg, gpc_in_if, gpc_out_if and the RTL of the checker.
// Commands are predicted in-bench; result words are compared field by field.
module general_position_point_set_checker_top_tb;

  localparam int NPTS  = 40;
  localparam int NSIDE = 16;
  localparam int LIMIT = 20000000;
  localparam int AXES [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                 '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  typedef struct packed {
    logic [1:0]      cmd;
    gpc_pkg::point_t pt;
  } cmd_word_t;

  typedef struct packed {
    logic       fits;
    logic [1:0] verdict;
    logic       sym;
    logic [5:0] total;
    logic [1:0] status;
  } res_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;

  gpc_in_if  in_if ();
  gpc_out_if out_if ();

  general_position_point_set_checker_top #(
    .MAX_POINTS (NPTS),
    .MAX_SIDE   (NSIDE)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // shadow of the block
  gpc_pkg::point_t stack_pts [NPTS];
  int              stack_cnt;
  int              layer_cnt [3][NSIDE];
  logic [4:0]      side_reg;

  cmd_word_t  pend_q [$];
  res_word_t  result_q [$];
  cmd_word_t  cur_word;
  int         send_gap, stall_left, hold_left, cycles, errors, checked;
  int         cmd_seen [4];
  int         sym_hits, full_hits;
  bit         calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int side_eff();
    if (side_reg < gpc_pkg::SIDE_MIN) return 2;
    if (side_reg > NSIDE) return NSIDE;
    return int'(side_reg);
  endfunction

  function automatic int c(gpc_pkg::point_t p, int a);
    return int'(p[a]);
  endfunction

  function automatic logic [1:0] judge_point(gpc_pkg::point_t q);
    int a, b, d;
    longint ux, uy, uz, vx, vy, vz, wx, wy, wz, det;
    for (a = 0; a < 3; a++)
      if (layer_cnt[a][q[a]] >= gpc_pkg::LAYER_LIMIT) return gpc_pkg::VERD_LAYER;
    for (a = 0; a < stack_cnt; a++)
      if (stack_pts[a] == q) return gpc_pkg::VERD_COLLINEAR;
    for (a = 0; a < stack_cnt; a++)
      for (b = a + 1; b < stack_cnt; b++) begin
        ux = c(stack_pts[b], 0) - c(stack_pts[a], 0);
        uy = c(stack_pts[b], 1) - c(stack_pts[a], 1);
        uz = c(stack_pts[b], 2) - c(stack_pts[a], 2);
        vx = c(q, 0) - c(stack_pts[a], 0);
        vy = c(q, 1) - c(stack_pts[a], 1);
        vz = c(q, 2) - c(stack_pts[a], 2);
        if (uy * vz == uz * vy && uz * vx == ux * vz && ux * vy == uy * vx)
          return gpc_pkg::VERD_COLLINEAR;
      end
    for (a = 0; a < stack_cnt; a++)
      for (b = a + 1; b < stack_cnt; b++)
        for (d = b + 1; d < stack_cnt; d++) begin
          ux = c(stack_pts[b], 0) - c(stack_pts[a], 0);
          uy = c(stack_pts[b], 1) - c(stack_pts[a], 1);
          uz = c(stack_pts[b], 2) - c(stack_pts[a], 2);
          vx = c(stack_pts[d], 0) - c(stack_pts[a], 0);
          vy = c(stack_pts[d], 1) - c(stack_pts[a], 1);
          vz = c(stack_pts[d], 2) - c(stack_pts[a], 2);
          wx = c(q, 0) - c(stack_pts[a], 0);
          wy = c(q, 1) - c(stack_pts[a], 1);
          wz = c(q, 2) - c(stack_pts[a], 2);
          det = ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx) +
                uz * (vx * wy - vy * wx);
          if (det == 0) return gpc_pkg::VERD_COPLANAR;
        end
    return gpc_pkg::VERD_FITS;
  endfunction

  function automatic logic set_is_symmetric();
    int m, p, s, i, j, a;
    int t [3];
    bit ok, hit;
    m = side_eff() - 1;
    for (p = 0; p < 6; p++)
      for (s = 0; s < 8; s++) begin
        if (p == 0 && s == 0) continue;
        ok = 1'b1;
        for (i = 0; i < stack_cnt && ok; i++) begin
          for (a = 0; a < 3; a++) begin
            t[a] = c(stack_pts[i], AXES[p][a]);
            if (s[a]) t[a] = m - t[a];
          end
          hit = 1'b0;
          for (j = 0; j < stack_cnt; j++)
            if (c(stack_pts[j], 0) == t[0] && c(stack_pts[j], 1) == t[1] &&
                c(stack_pts[j], 2) == t[2]) hit = 1'b1;
          if (!hit) ok = 1'b0;
        end
        if (ok) return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic void predict_word(cmd_word_t w);
    res_word_t r;
    int a, n;
    r = '0;
    n = side_eff();
    cmd_seen[w.cmd]++;
    case (w.cmd)
      gpc_pkg::CMD_TEST, gpc_pkg::CMD_PUSH: begin
        if (int'(w.pt[0]) >= n || int'(w.pt[1]) >= n || int'(w.pt[2]) >= n) begin
          r.status = gpc_pkg::STAT_OUTSIDE;
        end else begin
          r.verdict = judge_point(w.pt);
          r.fits    = (r.verdict == gpc_pkg::VERD_FITS);
          if (w.cmd == gpc_pkg::CMD_PUSH) begin
            if (stack_cnt >= NPTS) begin
              r.status = gpc_pkg::STAT_FULL;
              full_hits++;
            end else if (r.fits) begin
              stack_pts[stack_cnt] = w.pt;
              for (a = 0; a < 3; a++) layer_cnt[a][w.pt[a]]++;
              stack_cnt++;
            end
          end
        end
      end
      gpc_pkg::CMD_POP: begin
        if (stack_cnt == 0) begin
          r.status = gpc_pkg::STAT_EMPTY;
        end else begin
          stack_cnt--;
          for (a = 0; a < 3; a++)
            if (layer_cnt[a][stack_pts[stack_cnt][a]] > 0)
              layer_cnt[a][stack_pts[stack_cnt][a]]--;
        end
      end
      default: begin
        r.sym = set_is_symmetric();
        sym_hits += r.sym;
      end
    endcase
    r.total = stack_cnt[5:0];
    result_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (in_if.valid) predict_word(cur_word);
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur_word = pend_q.pop_front();
        in_if.command <= cur_word.cmd;
        in_if.px <= cur_word.pt[0];
        in_if.py <= cur_word.pt[1];
        in_if.pz <= cur_word.pt[2];
        in_if.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    res_word_t e;
    if (out_if.valid && out_if.ready) begin
      checked++;
      if (result_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_if.fits_flag !== e.fits) begin
          $error("fits_flag: expected %0d, got %0d", e.fits, out_if.fits_flag);
          errors++;
        end
        if (out_if.verdict !== e.verdict) begin
          $error("verdict: expected %0d, got %0d", e.verdict, out_if.verdict);
          errors++;
        end
        if (out_if.symmetric !== e.sym) begin
          $error("symmetric: expected %0d, got %0d", e.sym, out_if.symmetric);
          errors++;
        end
        if (out_if.point_total !== e.total) begin
          $error("point_total: expected %0d, got %0d", e.total, out_if.point_total);
          errors++;
        end
        if (out_if.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_if.status);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(99) < 25) stall_left = pick_gap();
    end
  end

  // long receiver hold-off
  always @(posedge clk_i)
    if (hold_left > 0) hold_left <= hold_left - 1;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, int x, int y, int z);
    cmd_word_t w;
    w.cmd = cmd;
    w.pt  = {gpc_pkg::coord_t'(z), gpc_pkg::coord_t'(y), gpc_pkg::coord_t'(x)};
    pend_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || in_if.valid || result_q.size() > 0 || send_gap > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_side(logic [4:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    side_reg = v;
  endtask

  // pushes most often; some candidates are built from stored points to hit lines and planes
  task automatic send_random(int num);
    int i, r, n, a, b, d, k;
    int q [3];
    logic [1:0] cmd;
    for (i = 0; i < num; i++) begin
      r = $urandom_range(99);
      cmd = r < 45 ? gpc_pkg::CMD_PUSH : r < 70 ? gpc_pkg::CMD_TEST :
            r < 85 ? gpc_pkg::CMD_POP : gpc_pkg::CMD_QUERY;
      n = side_eff();
      for (k = 0; k < 3; k++) q[k] = $urandom_range(n - 1);
      r = $urandom_range(99);
      if (r < 10) begin
        for (k = 0; k < 3; k++) q[k] = $urandom_range(15);
      end else if (r < 30 && stack_cnt >= 2) begin
        a = $urandom_range(stack_cnt - 1);
        b = $urandom_range(stack_cnt - 1);
        d = $urandom_range(stack_cnt - 1);
        for (k = 0; k < 3; k++)
          q[k] = (r < 20 || stack_cnt < 3) ?
                 2 * c(stack_pts[b], k) - c(stack_pts[a], k) :
                 c(stack_pts[a], k) + c(stack_pts[b], k) - c(stack_pts[d], k);
        for (k = 0; k < 3; k++)
          if (q[k] < 0 || q[k] > 15) q[k] = $urandom_range(n - 1);
      end
      send(cmd, q[0], q[1], q[2]);
      if (i % 8 == 7) wait_idle();
    end
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.command = gpc_pkg::CMD_TEST;
    in_if.px = '0;
    in_if.py = '0;
    in_if.pz = '0;
    out_if.ready = 1'b0;
    side_reg = gpc_pkg::SIDE_RESET;
    stack_cnt = 0;
    for (k = 0; k < 3 * NSIDE; k++) layer_cnt[k / NSIDE][k % NSIDE] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset side
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    send(gpc_pkg::CMD_POP, 0, 0, 0);
    send(gpc_pkg::CMD_TEST, 4, 0, 0);
    send(gpc_pkg::CMD_PUSH, 0, 15, 0);
    send(gpc_pkg::CMD_PUSH, 0, 0, 0);
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    send(gpc_pkg::CMD_PUSH, 0, 0, 0);
    send(gpc_pkg::CMD_PUSH, 1, 1, 1);
    send(gpc_pkg::CMD_TEST, 2, 2, 2);
    send(gpc_pkg::CMD_PUSH, 0, 1, 2);
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    send(gpc_pkg::CMD_TEST, 1, 0, 0);
    send(gpc_pkg::CMD_PUSH, 0, 3, 1);
    send(gpc_pkg::CMD_TEST, 0, 2, 3);
    send(gpc_pkg::CMD_TEST, 3, 3, 3);
    send(gpc_pkg::CMD_PUSH, 2, 0, 3);
    send(gpc_pkg::CMD_POP, 0, 0, 0);
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    wait_idle();

    // wider grid with points kept; receiver held off while words keep coming
    write_side(5'd16);
    send(gpc_pkg::CMD_TEST, 15, 15, 15);
    send(gpc_pkg::CMD_PUSH, 15, 15, 15);
    hold_left = 400;
    send_random(16);
    wait_idle();

    write_side(5'd0);
    send_random(8);
    wait_idle();
    write_side(5'd31);
    calm = 1'b1;
    send_random(10);
    wait_idle();
    calm = 1'b0;
    k = 0;
    while (stack_cnt < NPTS && k < 2) begin
      send_random(8);
      wait_idle();
      k++;
    end
    send(gpc_pkg::CMD_PUSH, 14, 2, 9);
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    wait_idle();
    write_side(5'd5);
    send_random(8);
    wait_idle();
    write_side(5'd9);
    send_random(8);
    wait_idle();
    write_side(5'd1);
    send_random(4);
    wait_idle();
    write_side(5'd3);
    repeat (stack_cnt + 1) send(gpc_pkg::CMD_POP, 0, 0, 0);
    send(gpc_pkg::CMD_QUERY, 0, 0, 0);
    wait_idle();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d tests, %0d pushes, %0d pops, %0d queries; %0d words checked.",
             cmd_seen[gpc_pkg::CMD_TEST], cmd_seen[gpc_pkg::CMD_PUSH],
             cmd_seen[gpc_pkg::CMD_POP], cmd_seen[gpc_pkg::CMD_QUERY], checked);
    $display("Symmetric answers %0d, pushes on a full stack %0d, grid sides 2 to 16.",
             sym_hits, full_hits);
    if (errors == 0 && result_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
hdl/gpc_pkg.sv
hdl/gpc_in_if.sv
hdl/gpc_out_if.sv
hdl/gpc_datapath.sv
hdl/gpc_ctrl.sv
hdl/general_position_point_set_checker_top.sv
hdl/gpc_checker.sv
test/general_position_point_set_checker_top_tb.sv
